/* src/autokey_xor_frame_decrypter_assert.svh */
// Assertion macros shared by the frame decrypter modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef AUTOKEY_XOR_FRAME_DECRYPTER_ASSERT_SVH
`define AUTOKEY_XOR_FRAME_DECRYPTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/afd_pkg.sv */
// Shared types and constants of the autokey XOR frame decrypter.
// No dependencies; every other file except the assertion header uses this package.
package afd_pkg;

  localparam int ByteW       = 8;
  localparam int KeyW        = 64;
  localparam int KeyLenW     = 4;
  localparam int KeyPosW     = 3;
  localparam int CountW      = 5;
  localparam int CfgIndexW   = 1;
  localparam int CfgDataW    = 64;
  localparam int KindW       = 2;
  localparam int StatusW     = 3;
  localparam int DefKeyBytes = 8;
  localparam int DefMaxArgs  = 16;
  localparam int ShortLimit  = 3;
  localparam int QueueDepth  = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_KEY_BYTES  = 1'b0,
    CFG_KEY_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [KindW-1:0] {
    KIND_SALT  = 2'd0,
    KIND_ARG   = 2'd1,
    KIND_CHECK = 2'd2
  } byte_kind_t;

  typedef enum logic [StatusW-1:0] {
    ST_MID   = 3'd0,
    ST_OK    = 3'd1,
    ST_BAD   = 3'd2,
    ST_SHORT = 3'd3,
    ST_LONG  = 3'd4
  } frame_status_t;

  // One classified byte on its way from the front part to the back part.
  // A status of ST_OK is tentative until the checksum is compared.
  typedef struct packed {
    logic [ByteW-1:0] cipher_byte;
    logic [ByteW-1:0] key_byte;
    logic             first;
    byte_kind_t       kind;
    frame_status_t    status;
  } afd_item_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic      valid;
    afd_item_t item;
  } afd_head_t;

endpackage

/* src/afd_if.sv */
// Valid/ready channel interfaces for the decrypter's input and result streams.
// Depends on afd_pkg for field widths.
interface afd_in_if;
  logic                       valid;
  logic                       ready;
  logic [afd_pkg::ByteW-1:0]  cipher_byte;
  logic                       frame_first;
  logic                       frame_last;

  modport source (output valid, output cipher_byte, output frame_first,
                  output frame_last, input ready);
  modport sink (input valid, input cipher_byte, input frame_first,
                input frame_last, output ready);
endinterface

interface afd_out_if;
  logic                         valid;
  logic                         ready;
  logic [afd_pkg::ByteW-1:0]    plain_byte;
  logic [afd_pkg::KindW-1:0]    byte_kind;
  logic [afd_pkg::StatusW-1:0]  frame_status;

  modport source (output valid, output plain_byte, output byte_kind,
                  output frame_status, input ready);
  modport sink (input valid, input plain_byte, input byte_kind,
                input frame_status, output ready);
endinterface

/* src/afd_front.sv */
// Front part: configuration registers, key position and byte counting.
// Classifies each accepted byte and pushes it into the queue. Uses afd_pkg, afd_in_if.
module afd_front #(
  parameter int KEY_BYTES = afd_pkg::DefKeyBytes,
  parameter int MAX_ARGS  = afd_pkg::DefMaxArgs
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [afd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [afd_pkg::CfgDataW-1:0]  cfg_data,
  afd_in_if.sink                        in_ch,
  input  logic                          q_full,
  output logic                          push,
  output afd_pkg::afd_item_t            push_item
);
  import afd_pkg::*;

  localparam logic [KeyLenW-1:0] KeyLimit  = KeyLenW'(KEY_BYTES);
  localparam int                 LongLimit = MAX_ARGS + ShortLimit;
  localparam logic [CountW-1:0]  CountMax  = {CountW{1'b1}};

  logic [KeyW-1:0]    key_bytes_r;
  logic [KeyLenW-1:0] key_length_r;
  logic [KeyPosW-1:0] key_pos_r, key_pos_nxt;
  logic [CountW-1:0]  seen_r, seen_nxt;
  logic [KeyLenW-1:0] len_use;
  logic [KeyPosW-1:0] pos_in, pos;
  logic [CountW-1:0]  idx, size;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= '0;
      key_length_r <= KeyLenW'(DefKeyBytes);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KEY_BYTES:  key_bytes_r  <= cfg_data[KeyW-1:0];
        CFG_KEY_LENGTH: key_length_r <= cfg_data[KeyLenW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Key length in use, clamped to one and to the key storage.
  always_comb begin
    if (key_length_r == '0) begin
      len_use = KeyLenW'(1);
    end else if (key_length_r > KeyLimit) begin
      len_use = KeyLimit;
    end else begin
      len_use = key_length_r;
    end
  end

  // Classification of the incoming byte; a frame start clears position and count.
  always_comb begin
    pos_in = in_ch.frame_first ? '0 : key_pos_r;
    pos    = ({1'b0, pos_in} >= len_use) ? '0 : pos_in;
    idx    = in_ch.frame_first ? '0 : seen_r;
    size   = (idx == CountMax) ? CountMax : idx + CountW'(1);

    key_pos_nxt = pos + KeyPosW'(1);
    seen_nxt    = size;

    push_item.cipher_byte = in_ch.cipher_byte;
    push_item.key_byte    = key_bytes_r[ByteW*pos +: ByteW];
    push_item.first       = in_ch.frame_first;

    if (in_ch.frame_last) begin
      push_item.kind = KIND_CHECK;
    end else if (idx < CountW'(2)) begin
      push_item.kind = KIND_SALT;
    end else begin
      push_item.kind = KIND_ARG;
    end

    if (!in_ch.frame_last) begin
      push_item.status = ST_MID;
    end else if (32'(size) <= ShortLimit) begin
      push_item.status = ST_SHORT;
    end else if (32'(size) > LongLimit) begin
      push_item.status = ST_LONG;
    end else begin
      push_item.status = ST_OK;
    end
  end

  // Frame state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pos_r <= '0;
      seen_r    <= '0;
    end else if (push) begin
      key_pos_r <= key_pos_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

/* src/afd_queue.sv */
// Short FIFO between the front and back parts of the decrypter.
// Uses afd_pkg for the item type and assertion macros from the shared header.
`include "autokey_xor_frame_decrypter_assert.svh"
module afd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  afd_pkg::afd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output afd_pkg::afd_head_t head
);
  import afd_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  afd_item_t       mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == DepthC);
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

  `AFD_ASSERT_IMPLIES(a_no_overflow, push, count_r != DepthC || pop, "queue overflow")
  `AFD_ASSERT_IMPLIES(a_no_underflow, pop, count_r != '0, "queue underflow")
  `AFD_ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= DepthC, "queue count out of range")

endmodule

/* src/afd_back.sv */
// Back part: plaintext recovery, running checksum and the result register.
// Uses afd_pkg, afd_out_if and assertion macros from the shared header.
`include "autokey_xor_frame_decrypter_assert.svh"
module afd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  afd_pkg::afd_head_t head,
  output logic               pop,
  afd_out_if.source          out_ch
);
  import afd_pkg::*;

  logic [ByteW-1:0] older_r, newer_r, sum_r;
  logic [ByteW-1:0] older_in, newer_in, sum_in, plain;
  logic             out_valid_r;
  logic [ByteW-1:0] plain_r;
  byte_kind_t       kind_r;
  frame_status_t    status_r, status;

  // Take the queue head whenever the result register is free or being emptied.
  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  // Decrypt the head byte; a frame start sees cleared history and sum.
  always_comb begin
    older_in = head.item.first ? '0 : older_r;
    newer_in = head.item.first ? '0 : newer_r;
    sum_in   = head.item.first ? '0 : sum_r;
    plain    = head.item.cipher_byte ^ older_in ^ newer_in ^ head.item.key_byte;
    status   = head.item.status;
    if (head.item.status == ST_OK && plain != sum_in) begin
      status = ST_BAD;
    end
  end

  // Plaintext history and checksum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      sum_r   <= '0;
    end else if (pop) begin
      older_r <= newer_in;
      newer_r <= plain;
      sum_r   <= sum_in + plain;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      plain_r  <= plain;
      kind_r   <= head.item.kind;
      status_r <= status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.plain_byte   = plain_r;
  assign out_ch.byte_kind    = kind_r;
  assign out_ch.frame_status = status_r;

  `AFD_ASSERT_IMPLIES(a_status_on_check, out_valid_r && status_r != ST_MID, kind_r == KIND_CHECK, "frame status on a non-checksum byte")
  `AFD_ASSERT_NEXT(a_history_tracks, pop, newer_r == plain_r, "plaintext history out of step with result")
  `AFD_ASSERT_IMPLIES(a_pop_needs_room, pop, !out_valid_r || out_ch.ready, "result overwritten before transfer")

endmodule

/* src/autokey_xor_frame_decrypter.sv */
// Autokey XOR frame decrypter, top level.
// Path: an accepted byte is written into the queue, then moved into the result register once that is free.
// Throughput: one byte per cycle while out_bus is ready; the two-entry queue and the result register set it.
// Reset (synchronous, active low) clears frame state, sets key_length to 8 and key to zero.
// No clearing pass: the block accepts bytes in the first cycle after reset.
// Uses afd_pkg, afd_if, afd_front, afd_queue and afd_back.
module autokey_xor_frame_decrypter #(
  parameter int KEY_BYTES = afd_pkg::DefKeyBytes,
  parameter int MAX_ARGS  = afd_pkg::DefMaxArgs
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [afd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [afd_pkg::CfgDataW-1:0]  cfg_data,
  afd_in_if.sink                        in_bus,
  afd_out_if.source                     out_bus
);
  import afd_pkg::*;

  logic      push, pop, q_full;
  afd_item_t push_item;
  afd_head_t head;

  // Front part: configuration and classification.
  afd_front #(
    .KEY_BYTES (KEY_BYTES),
    .MAX_ARGS  (MAX_ARGS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Queue between the two parts.
  afd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head)
  );

  // Back part: decryption, checksum and result.
  afd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_bus)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for autokey_xor_frame_decrypter: directed frames, then random
// frames under several key settings and handshake idling patterns. Needs afd_pkg, afd_if
// and the decrypter RTL.
`timescale 1ns / 100ps

module tb;
  import afd_pkg::*;

  // How the cipher of a byte is chosen: as given, or forced to a right or wrong checksum.
  localparam logic [1:0] SUM_RAW  = 2'd0;
  localparam logic [1:0] SUM_GOOD = 2'd1;
  localparam logic [1:0] SUM_BAD  = 2'd2;

  // Idling patterns of the two channel sides.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  localparam int QuietLimit     = 4000;
  localparam int LongHoldCycles = 80;
  localparam int PhaseItems     = 68;
  localparam int PressureItems  = 40;

  typedef struct packed {
    logic [ByteW-1:0] plain;
    byte_kind_t       kind;
    frame_status_t    status;
  } plain_result_t;

  typedef struct packed {
    logic [KeyPosW-1:0] key_pos;
    logic [ByteW-1:0]   prev2;
    logic [ByteW-1:0]   prev1;
    logic [ByteW-1:0]   sum;
    logic [CountW-1:0]  count;
  } frame_state_t;

  typedef struct packed {
    logic [ByteW-1:0] cipher;
    logic             first;
    logic             last;
    logic [1:0]       sum_mode;
    logic             typed;
    plain_result_t    result;
  } stim_row_t;

  localparam plain_result_t Untyped = '{8'h00, KIND_SALT, ST_MID};

  // Directed frames, all under the reset key (zero, length 8).
  localparam stim_row_t DirectedRows [22] = '{
    // First and last together: a one-byte frame.
    '{8'hA5, 1'b1, 1'b1, SUM_RAW, 1'b1, '{8'hA5, KIND_CHECK, ST_SHORT}},
    // A three-byte frame is still too short.
    '{8'h00, 1'b1, 1'b0, SUM_RAW, 1'b1, '{8'h00, KIND_SALT, ST_MID}},
    '{8'hFF, 1'b0, 1'b0, SUM_RAW, 1'b1, '{8'hFF, KIND_SALT, ST_MID}},
    '{8'h00, 1'b0, 1'b1, SUM_RAW, 1'b1, '{8'hFF, KIND_CHECK, ST_SHORT}},
    // No frame_first after a closed frame: the old state and count go on.
    '{8'h3C, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'hC3, 1'b0, 1'b1, SUM_RAW, 1'b0, Untyped},
    // Smallest frame that can pass.
    '{8'h80, 1'b1, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h01, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h7F, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h00, 1'b0, 1'b1, SUM_GOOD, 1'b0, Untyped},
    // Wrong checksum.
    '{8'h55, 1'b1, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'hAA, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h0F, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'hF0, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h00, 1'b0, 1'b1, SUM_BAD, 1'b0, Untyped},
    // Two-byte frame: the closing byte is a checksum byte even though it is short.
    '{8'hFF, 1'b1, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'hFF, 1'b0, 1'b1, SUM_RAW, 1'b0, Untyped},
    '{8'h00, 1'b1, 1'b1, SUM_RAW, 1'b1, '{8'h00, KIND_CHECK, ST_SHORT}},
    '{8'h12, 1'b1, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h34, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h56, 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped},
    '{8'h00, 1'b0, 1'b1, SUM_GOOD, 1'b0, Untyped}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  afd_in_if  in_if ();
  afd_out_if out_if ();

  autokey_xor_frame_decrypter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bus    (in_if),
    .out_bus   (out_if)
  );

  always #10 clk = ~clk;

  // Predictor copy of the registers and of the frame state.
  logic [KeyW-1:0]    key_word;
  logic [KeyLenW-1:0] key_len_reg;
  frame_state_t       tx_state;

  plain_result_t offered_q [$];
  plain_result_t plain_expected_q [$];

  int  idle_mode;
  bit  pressure_on;
  bit  pressure_done;
  int  hold_left;
  int  items_sent;
  int  settings_used;
  int  mismatches;
  int  quiet_cycles;
  int  results_checked;
  int  status_count [5];
  plain_result_t got;

  // Decrypts one byte and advances the frame state.
  function automatic plain_result_t decrypt_byte(inout frame_state_t st,
                                                 input logic [ByteW-1:0] cipher,
                                                 input logic first, input logic last);
    plain_result_t    r;
    int               len;
    int               pos;
    int               size;
    logic [ByteW-1:0] sum_before;
    if (first) st = '0;
    len = (key_len_reg == 0) ? 1 : (key_len_reg > DefKeyBytes) ? DefKeyBytes : key_len_reg;
    pos = st.key_pos;
    if (pos >= len) pos = 0;
    r.plain = cipher ^ st.prev2 ^ st.prev1 ^ key_word[8*pos +: 8];
    st.key_pos = KeyPosW'(pos + 1);
    st.prev2 = st.prev1;
    st.prev1 = r.plain;
    sum_before = st.sum;
    st.sum = st.sum + r.plain;
    size = (st.count >= 31) ? 31 : st.count + 1;
    r.kind = last ? KIND_CHECK : (st.count < 2) ? KIND_SALT : KIND_ARG;
    st.count = CountW'(size);
    r.status = ST_MID;
    if (last) begin
      if (size <= ShortLimit) r.status = ST_SHORT;
      else if (size - ShortLimit > DefMaxArgs) r.status = ST_LONG;
      else if (r.plain != sum_before) r.status = ST_BAD;
      else r.status = ST_OK;
    end
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Writes both registers; the block is idle whenever this is called.
  task automatic configure(input logic [KeyW-1:0] key, input logic [KeyLenW-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_BYTES;
    cfg_data  <= key;
    @(posedge clk);
    key_word  = key;
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data  <= (random_word() & ~64'hF) | 64'(len);
    @(posedge clk);
    key_len_reg = len;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offers one byte and returns once the transaction is accepted.
  task automatic send_byte(input logic [ByteW-1:0] cipher_in, input logic first,
                           input logic last, input logic [1:0] sum_mode,
                           input logic typed, input plain_result_t typed_res);
    frame_state_t     probe;
    plain_result_t    mask;
    plain_result_t    want;
    logic [ByteW-1:0] cipher;
    logic [ByteW-1:0] target;
    int               gap_pct;
    cipher = cipher_in;
    // Plaintext is linear in the cipher, so a zero cipher yields the mask to invert.
    if (sum_mode != SUM_RAW) begin
      probe  = tx_state;
      mask   = decrypt_byte(probe, 8'h00, first, last);
      target = probe.sum - mask.plain;
      if (sum_mode == SUM_BAD) target = target + 8'd1;
      cipher = target ^ mask.plain;
    end
    want = decrypt_byte(tx_state, cipher, first, last);
    if (typed) want = typed_res;
    gap_pct = (idle_mode == IDLE_SENDER) ? 59 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    offered_q.push_back(want);
    in_if.valid       <= 1'b1;
    in_if.cipher_byte <= cipher;
    in_if.frame_first <= first;
    in_if.frame_last  <= last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  // Mostly well-formed frames of random content; the rest are loose bytes.
  task automatic send_random_frame();
    int         n_args;
    int         pick;
    logic [1:0] close_mode;
    if ($urandom_range(0, 99) < 75) begin
      n_args = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 16) : $urandom_range(17, 40);
      pick = $urandom_range(0, 99);
      close_mode = (pick < 70) ? SUM_GOOD : (pick < 85) ? SUM_BAD : SUM_RAW;
      send_byte(ByteW'($urandom_range(0, 255)), 1'b1, 1'b0, SUM_RAW, 1'b0, Untyped);
      send_byte(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped);
      repeat (n_args)
        send_byte(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped);
      send_byte(ByteW'($urandom_range(0, 255)), 1'b0, 1'b1, close_mode, 1'b0, Untyped);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 1) ? SUM_GOOD : SUM_RAW,
                  1'b0, Untyped);
    end
  endtask

  // Waits until every expected result has come back, then lets the pipeline settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (offered_q.size() != 0 || plain_expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Result side: random stalls per idling pattern, plus one long hold-off.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on && !pressure_done) begin
        hold_left = LongHoldCycles;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
        out_if.ready <= ($urandom_range(0, 99) >= 59);
      end else if (idle_mode == IDLE_BOTH) begin
        out_if.ready <= ($urandom_range(0, 99) >= 12);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Moves predictions to the expected store on input transactions, checks output ones.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_if.valid && in_if.ready) begin
        quiet_cycles = 0;
        if (offered_q.size() != 0) plain_expected_q.push_back(offered_q.pop_front());
      end
      if (out_if.valid && out_if.ready) begin
        quiet_cycles = 0;
        if (plain_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction: plain %02h kind %0d status %0d",
                     $time, out_if.plain_byte, out_if.byte_kind, out_if.frame_status);
        end else begin
          got = plain_expected_q.pop_front();
          results_checked++;
          if (out_if.frame_status < 5) status_count[out_if.frame_status]++;
          if (out_if.plain_byte !== got.plain || out_if.byte_kind !== got.kind ||
              out_if.frame_status !== got.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: plain %02h/%02h kind %0d/%0d status %0d/%0d %s",
                       $time, got.plain, out_if.plain_byte, got.kind, out_if.byte_kind,
                       got.status, out_if.frame_status, "(expected/actual)");
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transaction for %0d cycles", QuietLimit);
        $display("autokey_xor_frame_decrypter verification failed");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed frames, then random phases under different keys.
  initial begin
    logic [KeyW-1:0]    key;
    logic [KeyLenW-1:0] len;
    int                 target;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_KEY_BYTES;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.cipher_byte <= '0;
    in_if.frame_first <= 1'b0;
    in_if.frame_last  <= 1'b0;
    key_word    = '0;
    key_len_reg = KeyLenW'(DefKeyBytes);
    tx_state    = '0;
    idle_mode   = IDLE_NONE;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 22; i++)
      send_byte(DirectedRows[i].cipher, DirectedRows[i].first, DirectedRows[i].last,
                DirectedRows[i].sum_mode, DirectedRows[i].typed, DirectedRows[i].result);
    drain();

    // Phase 8 is the pressure phase with a long receiver hold-off.
    for (int phase = 0; phase < 9; phase++) begin
      key = random_word();
      case (phase)
        0: begin key = '1; len = 4'd1; end
        1: begin key = '0; len = 4'd8; end
        2: len = 4'd0;
        3: len = 4'd15;
        4: begin key = 64'h0123_4567_89AB_CDEF; len = 4'd3; end
        5: len = 4'd9;
        6: len = KeyLenW'($urandom_range(0, 15));
        7: len = 4'd5;
        default: len = 4'd8;
      endcase
      configure(key, len);
      idle_mode = (phase == 8) ? IDLE_NONE : phase % 4;
      target = items_sent + ((phase == 8) ? PressureItems : PhaseItems);
      // A leftover frame continues across the key change, so the key position may wrap.
      send_byte(ByteW'($urandom_range(0, 255)), 1'b0, 1'b0, SUM_RAW, 1'b0, Untyped);
      if (phase == 8) pressure_on = 1'b1;
      while (items_sent < target) send_random_frame();
      drain();
    end

    $display("Checked %0d result bytes from %0d input bytes under %0d key settings.",
             results_checked, items_sent, settings_used);
    $display("Frames closed: ok %0d, bad checksum %0d, too short %0d, too long %0d.",
             status_count[ST_OK], status_count[ST_BAD], status_count[ST_SHORT],
             status_count[ST_LONG]);
    if (mismatches == 0 && plain_expected_q.size() == 0) begin
      $display("autokey_xor_frame_decrypter verification clean");
    end else begin
      $display("autokey_xor_frame_decrypter verification failed");
    end
    $finish;
  end

endmodule
